[sv/sqtc_pkg.sv]
// Package for the square transposition cipher: word types, codes and defaults.
`timescale 1ns / 1ps
`default_nettype none

package sqtc_pkg;

  // Default sizes
  localparam int MAX_SIDE_DEF = 8;
  localparam int MAX_LEN_DEF  = 64;

  // Fill character for cells past the message end
  localparam logic [7:0] PAD_CHAR = 8'h20;

  // Mode register codes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_char;
  } in_t;

  // Output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       truncated;
  } out_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

[sv/sqtc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sqtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/square_transposition_cipher.sv]
// Square transposition cipher: message store, side search and cell sequencer.
// Loading accepts one input word per cycle; in_ready is high only while loading.
// After the last word the n x n square is scanned cell by cell: RAM read, then evaluate,
// stalling while a held word waits on a busy output; a flush then releases any final word.
// Each kept cell waits in a holding register so that the final word can carry out_last.
// Synchronous reset clears control state and the mode; the byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module square_transposition_cipher #(
  parameter int MAX_SIDE = sqtc_pkg::MAX_SIDE_DEF,
  parameter int MAX_LEN  = sqtc_pkg::MAX_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sqtc_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sqtc_pkg::out_t     out_data
);

  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int NW   = $clog2(MAX_SIDE + 1);
  localparam int SW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int IW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int CMPW = (IW > CW) ? IW : CW;

  sqtc_pkg::state_t state, state_next;

  logic          mode;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] len, len_next;
  logic [NW-1:0] side, side_next;
  logic          dec, dec_next;
  logic          trunc, trunc_next;
  logic [SW-1:0] i, i_next;
  logic [SW-1:0] j, j_next;
  logic [IW-1:0] idx, idx_next;
  logic          pad, pad_next;
  logic [7:0]    hold, hold_next;
  logic          hold_valid, hold_valid_next;

  logic           push;
  sqtc_pkg::out_t push_data;
  logic           slot_free;

  logic            full;
  logic [CW-1:0]   len_new;
  logic [NW-1:0]   side_calc;
  logic [CMPW-1:0] idx_ext;
  logic [CMPW-1:0] len_ext;
  logic [7:0]      cell_byte;
  logic            emit;
  logic            j_end;
  logic            last_cell;

  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  // Byte store
  sqtc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (in_data.data_byte),
    .re    (ram_re),
    .raddr (idx_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Load-side helpers: length after this word and side of the square
  assign full    = (count == CW'(MAX_LEN));
  assign len_new = full ? count : count + CW'(1);

  always_comb begin
    side_calc = '0;
    for (int k = 0; k < MAX_SIDE; k++) begin
      if (k * k < int'(len_new)) begin
        side_calc = side_calc + NW'(1);
      end
    end
  end

  // Scan-side helpers
  assign idx_ext   = CMPW'(idx);
  assign len_ext   = CMPW'(len);
  assign cell_byte = pad ? sqtc_pkg::PAD_CHAR : ram_rdata;
  assign emit      = !(dec && (cell_byte == sqtc_pkg::PAD_CHAR));
  assign j_end     = ((NW'(j) + NW'(1)) == side);
  assign last_cell = j_end && ((NW'(i) + NW'(1)) == side);
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == sqtc_pkg::ST_LOAD);

  // Sequencer: next state and datapath controls
  always_comb begin
    state_next      = state;
    count_next      = count;
    ovf_next        = ovf;
    len_next        = len;
    side_next       = side;
    dec_next        = dec;
    trunc_next      = trunc;
    i_next          = i;
    j_next          = j;
    idx_next        = idx;
    pad_next        = pad;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    push            = 1'b0;
    push_data       = '0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    case (state)
      sqtc_pkg::ST_LOAD: begin
        if (in_valid) begin
          if (!full) begin
            ram_we     = 1'b1;
            count_next = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (in_data.last_char) begin
            len_next        = len_new;
            side_next       = side_calc;
            dec_next        = (mode == sqtc_pkg::MODE_DECRYPT);
            trunc_next      = ovf || full;
            count_next      = '0;
            ovf_next        = 1'b0;
            i_next          = '0;
            j_next          = '0;
            idx_next        = '0;
            hold_valid_next = 1'b0;
            state_next      = sqtc_pkg::ST_READ;
          end
        end
      end
      sqtc_pkg::ST_READ: begin
        ram_re     = 1'b1;
        pad_next   = !(idx_ext < len_ext);
        state_next = sqtc_pkg::ST_EVAL;
      end
      sqtc_pkg::ST_EVAL: begin
        // stall only when a held word must go out and the output is busy
        if (!(emit && hold_valid && !slot_free)) begin
          if (emit) begin
            if (hold_valid) begin
              push      = 1'b1;
              push_data = '{out_byte: hold, out_last: 1'b0, truncated: trunc};
            end
            hold_next       = cell_byte;
            hold_valid_next = 1'b1;
          end
          if (j_end) begin
            j_next   = '0;
            i_next   = i + SW'(1);
            idx_next = IW'(i) + IW'(1);
          end else begin
            j_next   = j + SW'(1);
            idx_next = idx + IW'(side);
          end
          state_next = last_cell ? sqtc_pkg::ST_FLUSH : sqtc_pkg::ST_READ;
        end
      end
      sqtc_pkg::ST_FLUSH: begin
        if (!hold_valid) begin
          state_next = sqtc_pkg::ST_LOAD;
        end else if (slot_free) begin
          push            = 1'b1;
          push_data       = '{out_byte: hold, out_last: 1'b1, truncated: trunc};
          hold_valid_next = 1'b0;
          state_next      = sqtc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = sqtc_pkg::ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sqtc_pkg::ST_LOAD;
      mode       <= sqtc_pkg::MODE_ENCRYPT;
      count      <= '0;
      ovf        <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      ovf        <= ovf_next;
      hold_valid <= hold_valid_next;
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    len   <= len_next;
    side  <= side_next;
    dec   <= dec_next;
    trunc <= trunc_next;
    i     <= i_next;
    j     <= j_next;
    idx   <= idx_next;
    pad   <= pad_next;
    hold  <= hold_next;
    if (push) begin
      out_data <= push_data;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_LEN)
    else $error("stored length exceeds capacity");

  a_idx_track: assert property (@(posedge clk) disable iff (rst)
    (state == sqtc_pkg::ST_READ) |-> (32'(idx) == 32'(j) * 32'(side) + 32'(i)))
    else $error("scan index out of step with row and column");

  a_last_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.last_char) |=>
      (state == sqtc_pkg::ST_READ) && (count == '0) && !ovf && !hold_valid)
    else $error("message end did not start a clean scan");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.out_last) |=> !hold_valid && (state == sqtc_pkg::ST_LOAD))
    else $error("final word left the holding register occupied");

  a_no_push_busy: assert property (@(posedge clk) disable iff (rst)
    push |-> slot_free)
    else $error("output overwritten while waiting");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the square transposition cipher: stimulus, cell predictor and output checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int SIDE_CAP     = sqtc_pkg::MAX_SIDE_DEF;
  localparam int STORE_DEPTH  = sqtc_pkg::MAX_LEN_DEF;
  localparam int DRAIN_CYCLES = 160;   // past the worst scan of a full square
  localparam int QUIET_LIMIT  = 5000;
  localparam int IDLE_PCT     = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sqtc_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sqtc_pkg::out_t out_data;

  // Stimulus and prediction state
  sqtc_pkg::in_t  pending_chars[$];
  sqtc_pkg::out_t expected_cells[$];
  logic [7:0] text_buf[STORE_DEPTH];
  int   text_len = 0;
  bit   text_dropped = 1'b0;
  logic cipher_mode = sqtc_pkg::MODE_ENCRYPT;
  bit   calm = 1'b0;
  logic char_taken = 1'b0;
  int   quiet_cycles = 0;
  int   errors = 0;
  int   chars_in = 0;
  int   cells_out = 0;
  int   messages = 0;
  int   truncated_msgs = 0;
  int   silent_msgs = 0;

  square_transposition_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Store one accepted char; on the last one, lay out the square and queue its cells
  task automatic absorb_char(input sqtc_pkg::in_t w);
    int side;
    int idx;
    logic [7:0] ch;
    sqtc_pkg::out_t cells[$];
    chars_in++;
    if (text_len < STORE_DEPTH) begin
      text_buf[text_len] = w.data_byte;
      text_len++;
    end else begin
      text_dropped = 1'b1;
    end
    if (w.last_char) begin
      side = 0;
      while (side * side < text_len && side < SIDE_CAP) side++;
      for (int r = 0; r < side; r++) begin
        for (int c = 0; c < side; c++) begin
          idx = c * side + r;
          ch = (idx < text_len) ? text_buf[idx] : sqtc_pkg::PAD_CHAR;
          if (cipher_mode == sqtc_pkg::MODE_DECRYPT && ch == sqtc_pkg::PAD_CHAR) continue;
          cells.push_back('{out_byte: ch, out_last: 1'b0, truncated: text_dropped});
        end
      end
      if (cells.size() > 0) cells[cells.size() - 1].out_last = 1'b1;
      else silent_msgs++;
      foreach (cells[k]) expected_cells.push_back(cells[k]);
      messages++;
      if (text_dropped) truncated_msgs++;
      text_len = 0;
      text_dropped = 1'b0;
    end
  endtask

  // Compare one output word against the oldest expected cell
  task automatic check_cell(input sqtc_pkg::out_t got);
    sqtc_pkg::out_t want;
    cells_out++;
    if (expected_cells.size() == 0) begin
      $display("%0t: unexpected word: expected none, got %h", $time, got);
      errors++;
    end else begin
      want = expected_cells.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $display("%0t: out_last expected %b, got %b", $time, want.out_last, got.out_last);
        errors++;
      end
      if (got.truncated !== want.truncated) begin
        $display("%0t: truncated expected %b, got %b", $time, want.truncated, got.truncated);
        errors++;
      end
    end
  endtask

  // Rising edge: register writes, accepted words, output checks, watchdog
  always @(posedge clk) begin
    char_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_we) cipher_mode = cfg_wdata;
      if (in_valid && in_ready) absorb_char(in_data);
      if (out_valid && out_ready) check_cell(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog: no traffic for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Driver: next word goes out once the held one is taken, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || char_taken) begin
      if (pending_chars.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data  <= pending_chars.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic push_char(input logic [7:0] b, input logic last);
    pending_chars.push_back('{data_byte: b, last_char: last});
  endtask

  // Random message; space_pct biases toward pad-like chars
  task automatic queue_message(input int len, input int space_pct);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      b = ($urandom_range(0, 99) < space_pct) ? sqtc_pkg::PAD_CHAR
                                              : 8'($urandom_range(0, 255));
      push_char(b, k == len - 1);
    end
  endtask

  // Mostly short messages, some near or past capacity, some all spaces
  task automatic queue_phase(input int target, input int space_pct);
    int made;
    int pick;
    int len;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        len = $urandom_range(60, 72);
        queue_message(len, space_pct);
      end else if (pick < 12) begin
        len = $urandom_range(1, 12);
        queue_message(len, 100);
      end else begin
        len = $urandom_range(1, 20);
        queue_message(len, space_pct);
      end
      made += len;
    end
  endtask

  // Wait for all words sent and all cells returned, then let the scan finish
  task automatic settle();
    while (pending_chars.size() != 0 || in_valid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, encrypt: one-cell squares, field extremes, full 2x2, padded 3x3
    write_mode(sqtc_pkg::MODE_ENCRYPT);
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    push_char(8'h00, 1'b0);
    push_char(8'h20, 1'b0);
    push_char(8'h7F, 1'b0);
    push_char(8'h80, 1'b1);
    for (int k = 0; k < 5; k++) push_char(8'h41 + 8'(k), k == 4);
    settle();

    // Directed, decrypt: all spaces gives nothing, genuine space skipped
    write_mode(sqtc_pkg::MODE_DECRYPT);
    push_char(sqtc_pkg::PAD_CHAR, 1'b0);
    push_char(sqtc_pkg::PAD_CHAR, 1'b0);
    push_char(sqtc_pkg::PAD_CHAR, 1'b1);
    push_char(sqtc_pkg::PAD_CHAR, 1'b0);
    push_char(8'h41, 1'b1);
    push_char(8'hFF, 1'b1);
    settle();

    // Random phases, both modes; full store and overflow forced in the first two
    write_mode(sqtc_pkg::MODE_ENCRYPT);
    queue_message(64, 10);
    queue_message(70, 10);
    queue_phase(20, 10);
    settle();

    write_mode(sqtc_pkg::MODE_DECRYPT);
    queue_message(64, 30);
    queue_message(67, 30);
    queue_phase(20, 30);
    settle();

    // One stretch with no gaps or stalls
    calm = 1'b1;
    write_mode(sqtc_pkg::MODE_ENCRYPT);
    queue_phase(25, 10);
    settle();
    calm = 1'b0;

    write_mode(sqtc_pkg::MODE_DECRYPT);
    queue_phase(25, 30);
    settle();

    $display("run covered %0d messages (%0d truncated, %0d decrypted to nothing),",
             messages, truncated_msgs, silent_msgs);
    $display("  %0d chars in and %0d cells out in both modes", chars_in, cells_out);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sqtc_pkg.sv
sv/sqtc_ram.sv
sv/square_transposition_cipher.sv
tb/sv/tb_top.sv
